// ===== rtl/cde_pkg.sv =====
// Shared types and codes for the circular deque engine.
// Used by cde_front, cde_fifo, cde_back and circular_deque_engine.
package cde_pkg;

  localparam int VALUE_W     = 32;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  // Request kind codes as they arrive on the input channel
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST      = 3'd4;

  // Internal operation codes after classification
  typedef logic [2:0] op_t;
  localparam op_t OP_INS_FRONT = 3'd0;
  localparam op_t OP_INS_BACK  = 3'd1;
  localparam op_t OP_DEL_FRONT = 3'd2;
  localparam op_t OP_DEL_BACK  = 3'd3;
  localparam op_t OP_LIST      = 3'd4;
  localparam op_t OP_NOP       = 3'd5;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Classified request held in the queue between front and back
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/circular_deque_engine.sv =====
// Double-ended queue of signed 32-bit values in a ring of CAPACITY entries.
// Requests pass through a two-entry queue to the back end, so the input keeps
// accepting while a result waits on the output. Insert, delete and unused
// kinds each give one result from the back end. A list request starts a
// walk over the stored entries, paced by the single read port of the ring
// store, and gives one result per entry (one empty result on an empty
// store). No clearing pass runs after reset: only entries that hold values
// are put on the output. Output stalls hold the back end; the input stalls
// only when the queue is full.
module circular_deque_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cde_pkg::KIND_W-1:0]         kind,
  input  logic signed [cde_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cde_pkg::STATUS_W-1:0]       status,
  output logic signed [cde_pkg::VALUE_W-1:0] entry,
  output logic [cde_pkg::OCC_W-1:0]          occupancy_out,
  output logic                               last
);

  logic          push_valid;
  cde_pkg::cmd_t push_cmd;
  logic          push_ready;
  logic          q_valid;
  cde_pkg::cmd_t q_cmd;
  logic          q_pop;

  // Accept and classify requests
  cde_front u_front (
    .valid      (in_valid),
    .stall      (in_stall),
    .kind       (kind),
    .value      (value),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // Decouple front from back
  cde_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  // Carry out requests on the ring
  cde_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .valid         (out_valid),
    .stall         (out_stall),
    .status        (status),
    .entry         (entry),
    .occupancy_out (occupancy_out),
    .last          (last)
  );

endmodule

// ===== rtl/cde_front.sv =====
// Front end: takes requests from the input channel and classifies them.
// Depends on cde_pkg; feeds cde_fifo.
module cde_front (
  input  logic                               valid,
  output logic                               stall,
  input  logic [cde_pkg::KIND_W-1:0]         kind,
  input  logic signed [cde_pkg::VALUE_W-1:0] value,
  output logic                               push_valid,
  output cde_pkg::cmd_t                      push_cmd,
  input  logic                               push_ready
);

  // Map the request kind to an internal operation; unused codes become no-ops
  always_comb begin
    unique case (kind)
      cde_pkg::KIND_INS_FRONT: push_cmd.op = cde_pkg::OP_INS_FRONT;
      cde_pkg::KIND_INS_BACK:  push_cmd.op = cde_pkg::OP_INS_BACK;
      cde_pkg::KIND_DEL_FRONT: push_cmd.op = cde_pkg::OP_DEL_FRONT;
      cde_pkg::KIND_DEL_BACK:  push_cmd.op = cde_pkg::OP_DEL_BACK;
      cde_pkg::KIND_LIST:      push_cmd.op = cde_pkg::OP_LIST;
      default:                 push_cmd.op = cde_pkg::OP_NOP;
    endcase
    push_cmd.value = value;
  end

  // Hold the requester off while the queue is full
  assign push_valid = valid;
  assign stall      = !push_ready;

endmodule

// ===== rtl/cde_fifo.sv =====
// Short request queue that decouples the front end from the back end.
// Depends on cde_pkg for the request type and depth.
module cde_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  cde_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output cde_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  localparam int DEPTH = cde_pkg::QUEUE_DEPTH;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cde_pkg::cmd_t    slots [DEPTH];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[head];
  assign push_ok    = push_valid && push_ready;
  assign pop_ok     = pop && pop_valid;

  // Store incoming requests at the tail
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[tail] <= push_cmd;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        tail <= (tail == IDX_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop_ok) begin
        head <= (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cde_back.sv =====
// Back end: ring store, front/back pointers, list sequencer and result register.
// Depends on cde_pkg; takes classified requests from cde_fifo.
module cde_back #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  cde_pkg::cmd_t                       q_cmd,
  output logic                                q_pop,
  output logic                                valid,
  input  logic                                stall,
  output logic [cde_pkg::STATUS_W-1:0]        status,
  output logic signed [cde_pkg::VALUE_W-1:0]  entry,
  output logic [cde_pkg::OCC_W-1:0]           occupancy_out,
  output logic                                last
);

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int OW    = cde_pkg::OCC_W;
  localparam int VW    = cde_pkg::VALUE_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

  logic signed [VW-1:0] mem [CAPACITY];
  logic signed [VW-1:0] rd_q;

  logic                 state;
  logic                 state_next;
  logic [PTR_W-1:0]     front_pos;
  logic [PTR_W-1:0]     front_pos_next;
  logic [PTR_W-1:0]     back_pos;
  logic [PTR_W-1:0]     back_pos_next;
  logic [CNT_W-1:0]     occupancy;
  logic [CNT_W-1:0]     occupancy_next;
  logic [PTR_W-1:0]     list_pos;
  logic [PTR_W-1:0]     list_pos_next;
  logic [CNT_W-1:0]     remain;
  logic [CNT_W-1:0]     remain_next;

  logic                 wr_en;
  logic [PTR_W-1:0]     wr_addr;
  logic                 out_free;
  logic                 load_out;
  cde_pkg::status_t     status_next;
  logic signed [VW-1:0] entry_next;
  logic [CNT_W-1:0]     count_next;
  logic                 last_next;
  logic                 is_full;
  logic                 is_empty;

  assign out_free = !valid || !stall;
  assign is_full  = (occupancy == CNT_W'(CAPACITY));
  assign is_empty = (occupancy == '0);

  // Sequence requests and build the next result
  always_comb begin
    state_next     = state;
    front_pos_next = front_pos;
    back_pos_next  = back_pos;
    occupancy_next = occupancy;
    list_pos_next  = list_pos;
    remain_next    = remain;
    wr_en          = 1'b0;
    wr_addr        = back_pos;
    q_pop          = 1'b0;
    load_out       = 1'b0;
    status_next    = cde_pkg::ST_OK;
    entry_next     = '0;
    count_next     = occupancy;
    last_next      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            cde_pkg::OP_INS_FRONT: begin
              load_out = 1'b1;
              if (is_full) begin
                status_next = cde_pkg::ST_FULL;
              end else begin
                front_pos_next = ring_prev(front_pos);
                wr_en          = 1'b1;
                wr_addr        = ring_prev(front_pos);
                occupancy_next = occupancy + 1'b1;
                count_next     = occupancy + 1'b1;
              end
            end
            cde_pkg::OP_INS_BACK: begin
              load_out = 1'b1;
              if (is_full) begin
                status_next = cde_pkg::ST_FULL;
              end else begin
                back_pos_next  = ring_next(back_pos);
                wr_en          = 1'b1;
                wr_addr        = back_pos;
                occupancy_next = occupancy + 1'b1;
                count_next     = occupancy + 1'b1;
              end
            end
            cde_pkg::OP_DEL_FRONT: begin
              load_out = 1'b1;
              if (is_empty) begin
                status_next = cde_pkg::ST_EMPTY;
              end else begin
                front_pos_next = ring_next(front_pos);
                occupancy_next = occupancy - 1'b1;
                count_next     = occupancy - 1'b1;
              end
            end
            cde_pkg::OP_DEL_BACK: begin
              load_out = 1'b1;
              if (is_empty) begin
                status_next = cde_pkg::ST_EMPTY;
              end else begin
                back_pos_next  = ring_prev(back_pos);
                occupancy_next = occupancy - 1'b1;
                count_next     = occupancy - 1'b1;
              end
            end
            cde_pkg::OP_LIST: begin
              if (is_empty) begin
                load_out    = 1'b1;
                status_next = cde_pkg::ST_EMPTY;
              end else begin
                // start the walk; front entry is read this cycle
                list_pos_next = front_pos;
                remain_next   = occupancy - 1'b1;
                state_next    = S_LIST;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          load_out      = 1'b1;
          entry_next    = rd_q;
          last_next     = (remain == '0);
          list_pos_next = ring_next(list_pos);
          remain_next   = remain - 1'b1;
          if (remain == '0) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Ring store: write on insert, read ahead at the next list position
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_cmd.value;
    end
    rd_q <= mem[list_pos_next];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_pos <= '0;
      back_pos  <= '0;
      occupancy <= '0;
      list_pos  <= '0;
      remain    <= '0;
      valid     <= 1'b0;
    end else begin
      state     <= state_next;
      front_pos <= front_pos_next;
      back_pos  <= back_pos_next;
      occupancy <= occupancy_next;
      list_pos  <= list_pos_next;
      remain    <= remain_next;
      if (load_out) begin
        valid <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= status_next;
      entry         <= entry_next;
      occupancy_out <= OW'(count_next);
      last          <= last_next;
    end
  end

endmodule
